// ===== rtl/rtpjb_pkg.sv =====
// Package: shared constants, types and codes of the RTP reorder jitter buffer.
`timescale 1ns / 1ps
package rtpjb_pkg;

  localparam int ENTRIES     = 32;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int SEQ_W       = 16;
  localparam int EXT_W       = 48;
  localparam int TIME_W      = 32;
  localparam int TAG_W       = 16;
  localparam int TMO_W       = 16;
  localparam int LIM_W       = 15;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [TMO_W-1:0] TIMEOUT_RST  = TMO_W'(200);
  localparam logic [LIM_W-1:0] DROPOUT_RST  = LIM_W'(3000);
  localparam logic [LIM_W-1:0] MISORDER_RST = LIM_W'(100);
  localparam logic [SEQ_W:0]   SUSPECT_NONE = 17'd65537;
  localparam logic [SEQ_W:0]   SEQ_MODULUS  = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROPOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISORDER = 2'd2;

  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESET   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP    = 2'd2;

  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef enum logic [1:0] {
    JOB_RSTREL,
    JOB_PKT,
    JOB_TICK
  } job_op_t;

  typedef struct packed {
    job_op_t           op;
    logic [EXT_W-1:0]  ext;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] at;
    logic [TIME_W-1:0] now;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_START,
    BK_REL_RST,
    BK_SCAN,
    BK_SCAN_END,
    BK_FIN
  } back_state_t;

  typedef enum logic [1:0] {
    MODE_CHAIN,
    MODE_HOLD,
    MODE_WALK
  } scan_mode_t;

endpackage

// ===== rtl/rtpjb_front.sv =====
// Front end: sequence extension and classification of arrivals into jobs.
`timescale 1ns / 1ps
module rtpjb_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic                             in_command,
  input  logic [rtpjb_pkg::SEQ_W-1:0]      in_seq,
  input  logic [rtpjb_pkg::TIME_W-1:0]     in_arrival_ms,
  input  logic [rtpjb_pkg::TIME_W-1:0]     in_now_ms,
  input  logic [rtpjb_pkg::TAG_W-1:0]      in_pkt_tag,
  input  logic [rtpjb_pkg::LIM_W-1:0]      dropout_lim,
  input  logic [rtpjb_pkg::LIM_W-1:0]      misorder_lim,
  output logic                             push,
  output rtpjb_pkg::job_t                  job
);

  logic                            started_r, started_nxt;
  logic [rtpjb_pkg::SEQ_W-1:0]     highest_r, highest_nxt;
  logic [rtpjb_pkg::SEQ_W:0]       suspect_r, suspect_nxt;
  logic [rtpjb_pkg::EXT_W-1:0]     wrap_r, wrap_nxt;

  logic [rtpjb_pkg::SEQ_W-1:0]     gap;
  logic                            in_order, far_jump;

  assign gap      = in_seq - highest_r;
  assign in_order = {1'b0, gap} < {2'b0, dropout_lim};
  assign far_jump = {1'b0, gap} <= (rtpjb_pkg::SEQ_MODULUS - {2'b0, misorder_lim});

  always_comb begin
    started_nxt = started_r;
    highest_nxt = highest_r;
    suspect_nxt = suspect_r;
    wrap_nxt    = wrap_r;
    push        = 1'b0;
    job.op      = rtpjb_pkg::JOB_PKT;
    job.ext     = wrap_r + rtpjb_pkg::EXT_W'(in_seq);
    job.tag     = in_pkt_tag;
    job.at      = in_arrival_ms;
    job.now     = in_now_ms;
    if (accept) begin
      if (in_command == rtpjb_pkg::CMD_TICK) begin
        push   = 1'b1;
        job.op = rtpjb_pkg::JOB_TICK;
      end else if (!started_r) begin
        started_nxt = 1'b1;
        highest_nxt = in_seq;
        suspect_nxt = rtpjb_pkg::SUSPECT_NONE;
        wrap_nxt    = '0;
        push        = 1'b1;
        job.op      = rtpjb_pkg::JOB_RSTREL;
        job.ext     = rtpjb_pkg::EXT_W'(in_seq);
      end else if (in_order) begin
        if (in_seq < highest_r) begin
          wrap_nxt = wrap_r + rtpjb_pkg::EXT_W'(rtpjb_pkg::SEQ_MODULUS);
        end
        highest_nxt = in_seq;
        push        = 1'b1;
        job.ext     = wrap_nxt + rtpjb_pkg::EXT_W'(in_seq);
      end else if (far_jump) begin
        if ({1'b0, in_seq} == suspect_r) begin
          // far packet one past the previous far one: resync
          highest_nxt = in_seq;
          suspect_nxt = rtpjb_pkg::SUSPECT_NONE;
          wrap_nxt    = '0;
          push        = 1'b1;
          job.op      = rtpjb_pkg::JOB_RSTREL;
          job.ext     = rtpjb_pkg::EXT_W'(in_seq);
        end else begin
          suspect_nxt = {1'b0, in_seq + 16'd1};
        end
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      highest_r <= '0;
      suspect_r <= rtpjb_pkg::SUSPECT_NONE;
      wrap_r    <= '0;
    end else begin
      started_r <= started_nxt;
      highest_r <= highest_nxt;
      suspect_r <= suspect_nxt;
      wrap_r    <= wrap_nxt;
    end
  end

endmodule

// ===== rtl/rtpjb_fifo.sv =====
// Two-entry job queue between front end and store engine.
`timescale 1ns / 1ps
module rtpjb_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rtpjb_pkg::job_t push_job,
  input  logic            pop,
  output rtpjb_pkg::job_t head,
  output logic            empty,
  output logic            full
);

  rtpjb_pkg::job_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;

  assign head  = mem_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/rtpjb_back.sv =====
// Back end: held-packet store, ordered release, timeout walk and result output.
`timescale 1ns / 1ps
module rtpjb_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rtpjb_pkg::job_t               head,
  input  logic                          empty,
  output logic                          pop,
  input  logic [rtpjb_pkg::TMO_W-1:0]   timeout_ms,
  output logic                          out_strobe,
  output logic [rtpjb_pkg::KIND_W-1:0]  out_kind,
  output logic [rtpjb_pkg::TAG_W-1:0]   out_tag,
  output logic [rtpjb_pkg::EXT_W-1:0]   out_ext_seq,
  output logic                          out_last
);

  localparam logic [rtpjb_pkg::IDX_W-1:0] IDX_LAST = rtpjb_pkg::IDX_W'(rtpjb_pkg::ENTRIES - 1);

  rtpjb_pkg::back_state_t state_r, state_nxt;
  rtpjb_pkg::scan_mode_t  mode_r, mode_nxt;
  rtpjb_pkg::job_t        job_r;

  logic [rtpjb_pkg::EXT_W-1:0]  lr_r, lr_inc;

  logic                         slot_valid_r [rtpjb_pkg::ENTRIES];
  logic [rtpjb_pkg::EXT_W-1:0]  slot_seq_r   [rtpjb_pkg::ENTRIES];
  logic [rtpjb_pkg::TAG_W-1:0]  slot_tag_r   [rtpjb_pkg::ENTRIES];
  logic [rtpjb_pkg::TIME_W-1:0] slot_time_r  [rtpjb_pkg::ENTRIES];

  logic [rtpjb_pkg::IDX_W-1:0]  idx_r;
  logic                         have_floor_r, have_floor_nxt;
  logic [rtpjb_pkg::EXT_W-1:0]  floor_r, floor_nxt;
  logic                         best_found_r, match_found_r, free_found_r;
  logic [rtpjb_pkg::IDX_W-1:0]  best_idx_r, match_idx_r, free_idx_r;
  logic [rtpjb_pkg::EXT_W-1:0]  best_seq_r;
  logic [rtpjb_pkg::TAG_W-1:0]  best_tag_r;
  logic [rtpjb_pkg::TIME_W-1:0] best_time_r;

  // per-cycle scan evaluation
  logic                         cur_v, cand, cur_match, cur_free;
  logic [rtpjb_pkg::EXT_W-1:0]  cur_key;
  logic [rtpjb_pkg::TIME_W-1:0] age;
  logic                         best_old;

  // actions
  logic                         emit;
  logic [rtpjb_pkg::KIND_W-1:0] emit_kind;
  logic [rtpjb_pkg::TAG_W-1:0]  emit_tag;
  logic [rtpjb_pkg::EXT_W-1:0]  emit_ext;
  logic                         set_lr, scan_start, clr_best, wr_slot, flush, take_job;
  logic [rtpjb_pkg::IDX_W-1:0]  wr_idx;

  // one result held back so the final one can carry last
  logic                         pend_v_r;
  logic [rtpjb_pkg::KIND_W-1:0] pend_kind_r;
  logic [rtpjb_pkg::TAG_W-1:0]  pend_tag_r;
  logic [rtpjb_pkg::EXT_W-1:0]  pend_ext_r;

  assign lr_inc    = lr_r + 48'd1;
  assign cur_v     = slot_valid_r[idx_r];
  assign cur_key   = slot_seq_r[idx_r];
  assign cand      = cur_v && (!have_floor_r || cur_key > floor_r) &&
                     (!best_found_r || cur_key < best_seq_r);
  assign cur_match = cur_v && (cur_key == job_r.ext) && !match_found_r;
  assign cur_free  = !cur_v && !free_found_r;
  assign age       = job_r.now - best_time_r;
  assign best_old  = !age[rtpjb_pkg::TIME_W-1] && (age > rtpjb_pkg::TIME_W'(timeout_ms));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtpjb_pkg::BK_IDLE:     if (!empty) state_nxt = rtpjb_pkg::BK_START;
      rtpjb_pkg::BK_START: begin
        if (job_r.op == rtpjb_pkg::JOB_RSTREL) state_nxt = rtpjb_pkg::BK_REL_RST;
        else                                   state_nxt = rtpjb_pkg::BK_SCAN;
      end
      rtpjb_pkg::BK_REL_RST:  state_nxt = rtpjb_pkg::BK_FIN;
      rtpjb_pkg::BK_SCAN:     if (idx_r == IDX_LAST) state_nxt = rtpjb_pkg::BK_SCAN_END;
      rtpjb_pkg::BK_SCAN_END: begin
        unique case (mode_r)
          rtpjb_pkg::MODE_CHAIN: begin
            if (best_found_r && best_seq_r == lr_inc) state_nxt = rtpjb_pkg::BK_SCAN;
            else                                      state_nxt = rtpjb_pkg::BK_FIN;
          end
          rtpjb_pkg::MODE_HOLD: state_nxt = rtpjb_pkg::BK_SCAN;
          rtpjb_pkg::MODE_WALK: begin
            if (best_found_r) state_nxt = rtpjb_pkg::BK_SCAN;
            else              state_nxt = rtpjb_pkg::BK_FIN;
          end
          default: state_nxt = rtpjb_pkg::BK_FIN;
        endcase
      end
      rtpjb_pkg::BK_FIN:      state_nxt = rtpjb_pkg::BK_IDLE;
      default:                state_nxt = rtpjb_pkg::BK_IDLE;
    endcase
  end

  // actions
  always_comb begin
    take_job       = 1'b0;
    emit           = 1'b0;
    emit_kind      = rtpjb_pkg::KIND_RELEASE;
    emit_tag       = job_r.tag;
    emit_ext       = job_r.ext;
    set_lr         = 1'b0;
    scan_start     = 1'b0;
    clr_best       = 1'b0;
    wr_slot        = 1'b0;
    wr_idx         = match_found_r ? match_idx_r : free_idx_r;
    flush          = 1'b0;
    mode_nxt       = mode_r;
    have_floor_nxt = have_floor_r;
    floor_nxt      = floor_r;
    unique case (state_r)
      rtpjb_pkg::BK_IDLE: take_job = !empty;
      rtpjb_pkg::BK_START: begin
        unique case (job_r.op)
          rtpjb_pkg::JOB_RSTREL: begin
            emit      = 1'b1;
            emit_kind = rtpjb_pkg::KIND_RESET;
          end
          rtpjb_pkg::JOB_PKT: begin
            scan_start     = 1'b1;
            have_floor_nxt = 1'b0;
            if (job_r.ext == lr_inc) begin
              emit     = 1'b1;
              set_lr   = 1'b1;
              mode_nxt = rtpjb_pkg::MODE_CHAIN;
            end else begin
              mode_nxt = rtpjb_pkg::MODE_HOLD;
            end
          end
          default: begin
            scan_start     = 1'b1;
            have_floor_nxt = 1'b0;
            mode_nxt       = rtpjb_pkg::MODE_WALK;
          end
        endcase
      end
      rtpjb_pkg::BK_REL_RST: begin
        emit   = 1'b1;
        set_lr = 1'b1;
      end
      rtpjb_pkg::BK_SCAN: ;
      rtpjb_pkg::BK_SCAN_END: begin
        unique case (mode_r)
          rtpjb_pkg::MODE_CHAIN: begin
            if (best_found_r && best_seq_r == lr_inc) begin
              emit       = 1'b1;
              emit_tag   = best_tag_r;
              emit_ext   = best_seq_r;
              set_lr     = 1'b1;
              clr_best   = 1'b1;
              scan_start = 1'b1;
            end
          end
          rtpjb_pkg::MODE_HOLD: begin
            if (match_found_r || free_found_r) begin
              wr_slot = 1'b1;
            end else begin
              emit      = 1'b1;
              emit_kind = rtpjb_pkg::KIND_DROP;
            end
            mode_nxt       = rtpjb_pkg::MODE_WALK;
            have_floor_nxt = 1'b0;
            scan_start     = 1'b1;
          end
          default: begin
            if (best_found_r) begin
              have_floor_nxt = 1'b1;
              floor_nxt      = best_seq_r;
              scan_start     = 1'b1;
              if (best_old || best_seq_r == lr_inc) begin
                emit     = 1'b1;
                emit_tag = best_tag_r;
                emit_ext = best_seq_r;
                set_lr   = 1'b1;
                clr_best = 1'b1;
              end
            end
          end
        endcase
      end
      rtpjb_pkg::BK_FIN: flush = 1'b1;
      default: ;
    endcase
  end

  assign pop = take_job;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rtpjb_pkg::BK_IDLE;
      mode_r       <= rtpjb_pkg::MODE_WALK;
      lr_r         <= '0;
      have_floor_r <= 1'b0;
      pend_v_r     <= 1'b0;
      out_strobe   <= 1'b0;
      for (int i = 0; i < rtpjb_pkg::ENTRIES; i++) begin
        slot_valid_r[i] <= 1'b0;
      end
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      have_floor_r <= have_floor_nxt;
      out_strobe   <= 1'b0;
      if (set_lr)   lr_r <= emit_ext;
      if (clr_best) slot_valid_r[best_idx_r] <= 1'b0;
      if (wr_slot)  slot_valid_r[wr_idx] <= 1'b1;
      if (emit) begin
        pend_v_r <= 1'b1;
        if (pend_v_r) out_strobe <= 1'b1;
      end else if (flush && pend_v_r) begin
        pend_v_r   <= 1'b0;
        out_strobe <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    floor_r <= floor_nxt;
    if (take_job) job_r <= head;
    if (wr_slot) begin
      slot_seq_r[wr_idx]  <= job_r.ext;
      slot_tag_r[wr_idx]  <= job_r.tag;
      slot_time_r[wr_idx] <= job_r.at;
    end
    if (emit) begin
      pend_kind_r <= emit_kind;
      pend_tag_r  <= emit_tag;
      pend_ext_r  <= emit_ext;
      out_kind    <= pend_kind_r;
      out_tag     <= pend_tag_r;
      out_ext_seq <= pend_ext_r;
      out_last    <= 1'b0;
    end else if (flush) begin
      out_kind    <= pend_kind_r;
      out_tag     <= pend_tag_r;
      out_ext_seq <= pend_ext_r;
      out_last    <= 1'b1;
    end
    if (scan_start) begin
      idx_r         <= '0;
      best_found_r  <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (state_r == rtpjb_pkg::BK_SCAN) begin
      idx_r <= idx_r + 1'b1;
      if (cand) begin
        best_found_r <= 1'b1;
        best_idx_r   <= idx_r;
        best_seq_r   <= cur_key;
        best_tag_r   <= slot_tag_r[idx_r];
        best_time_r  <= slot_time_r[idx_r];
      end
      if (cur_match) begin
        match_found_r <= 1'b1;
        match_idx_r   <= idx_r;
      end
      if (cur_free) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_r;
      end
    end
  end

endmodule

// ===== rtl/rtp_reorder_jitter_buffer.sv =====
// Top level: RTP reorder jitter buffer with config registers, front end, job queue, store engine.
//
//  channel | handshake         | payload
//  --------+-------------------+------------------------------------------------
//  input   | start, busy       | in_command, in_seq, in_arrival_ms, in_now_ms,
//          |                   | in_pkt_tag
//  result  | out_strobe        | out_kind, out_tag, out_ext_seq, out_last
//  config  | cfg_we            | cfg_index, cfg_wdata
//
// A transaction is taken when start is high and busy low; the front end
// classifies it in that cycle and, except for a first far jump, queues a
// job (busy only while the two-entry queue is full). The store engine
// walks all ENTRIES slots once per search, one pass per held packet found.
// Results appear one per strobe cycle, each held back until the next one
// is known so the final one carries out_last; the receiver cannot stall.
// Reset is synchronous, active low, and clears all control state and the
// slot valid bits at once.
`timescale 1ns / 1ps
module rtp_reorder_jitter_buffer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_command,
  input  logic [rtpjb_pkg::SEQ_W-1:0]         in_seq,
  input  logic [rtpjb_pkg::TIME_W-1:0]        in_arrival_ms,
  input  logic [rtpjb_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [rtpjb_pkg::TAG_W-1:0]         in_pkt_tag,
  output logic                                out_strobe,
  output logic [rtpjb_pkg::KIND_W-1:0]        out_kind,
  output logic [rtpjb_pkg::TAG_W-1:0]         out_tag,
  output logic [rtpjb_pkg::EXT_W-1:0]         out_ext_seq,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [rtpjb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtpjb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [rtpjb_pkg::TMO_W-1:0] timeout_r;
  logic [rtpjb_pkg::LIM_W-1:0] dropout_r, misorder_r;

  logic            accept, push, pop, q_empty, q_full;
  rtpjb_pkg::job_t push_job, head;

  assign busy   = q_full;
  assign accept = start && !busy;

  // config registers; unknown index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= rtpjb_pkg::TIMEOUT_RST;
      dropout_r  <= rtpjb_pkg::DROPOUT_RST;
      misorder_r <= rtpjb_pkg::MISORDER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtpjb_pkg::REG_TIMEOUT:  timeout_r  <= cfg_wdata;
        rtpjb_pkg::REG_DROPOUT:  dropout_r  <= cfg_wdata[rtpjb_pkg::LIM_W-1:0];
        rtpjb_pkg::REG_MISORDER: misorder_r <= cfg_wdata[rtpjb_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  rtpjb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_command    (in_command),
    .in_seq        (in_seq),
    .in_arrival_ms (in_arrival_ms),
    .in_now_ms     (in_now_ms),
    .in_pkt_tag    (in_pkt_tag),
    .dropout_lim   (dropout_r),
    .misorder_lim  (misorder_r),
    .push          (push),
    .job           (push_job)
  );

  rtpjb_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rtpjb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .timeout_ms  (timeout_r),
    .out_strobe  (out_strobe),
    .out_kind    (out_kind),
    .out_tag     (out_tag),
    .out_ext_seq (out_ext_seq),
    .out_last    (out_last)
  );

endmodule
